@@ rtl/core/deq_pkg.sv @@
// deq_pkg: sizes, operation codes, status codes and control structs for the deque core.
// No dependencies. Used by every file under rtl/core.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEPTH  = 128;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int OCC_W  = 8;
  localparam int STAT_W = 2;

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_POP_FRONT  = 2'd1,
    OP_PUSH_FRONT = 2'd2,
    OP_POP_BACK   = 2'd3
  } deq_op_t;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  localparam logic signed [WORD_W-1:0] NO_DATA = '1;

  // controller -> datapath
  typedef struct packed {
    logic exec;    // item accepted this cycle
    logic finish;  // read data is ready, load it into the result register
  } deq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pop_ok;  // current item is a pop that will succeed
  } deq_sts_t;

endpackage

@@ rtl/core/deq_ifs.sv @@
// deq_in_if / deq_out_if: valid-ready channels for operation items and result items.
// Depends on deq_pkg.
`timescale 1ns / 1ps

interface deq_in_if import deq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               mode;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface deq_out_if import deq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] data;
  logic [STAT_W-1:0]        status;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output data, output status, output occupancy, input ready);
  modport sink   (input valid, input data, input status, input occupancy, output ready);
endinterface

@@ rtl/core/deq_ctrl.sv @@
// deq_ctrl: handshake controller for the deque core; sequences pops through the store read.
// Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_ctrl import deq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  deq_sts_t sts,
  output deq_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready   = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept     = in_valid && in_ready;
  assign cmd.exec   = accept;
  assign cmd.finish = (state_r == S_READ);
  assign out_valid  = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (sts.pop_ok) begin
            state_nxt = S_READ;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_READ: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_read_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> out_valid_r)
    else $error("result not presented after store read");

  a_no_accept_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> !in_ready)
    else $error("item accepted while a pop is in flight");

  a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !sts.pop_ok) |=> (out_valid_r && state_r == S_IDLE))
    else $error("push or refused pop did not yield a result next cycle");

endmodule

@@ rtl/core/deq_dp.sv @@
// deq_dp: deque datapath - circular store, front/back pointers, count and result register.
// Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_dp import deq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [1:0]               mode,
  input  logic signed [WORD_W-1:0] value,
  input  deq_cmd_t                 cmd,
  output deq_sts_t                 sts,
  output logic signed [WORD_W-1:0] data,
  output logic [STAT_W-1:0]        status,
  output logic [OCC_W-1:0]         occupancy
);

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW-1:0] front_r, front_nxt;
  logic [AW-1:0] back_r, back_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rdata_r;
  logic signed [WORD_W-1:0] data_r;
  logic [STAT_W-1:0]        status_r, status_nxt;
  logic [OCC_W-1:0]         occ_r;

  logic          full, empty, is_push, push_ok, pop_ok;
  logic [AW-1:0] front_up, front_dn, back_up, back_dn;
  logic [AW-1:0] wr_addr, rd_addr;
  deq_op_t       op;

  assign op    = deq_op_t'(mode);
  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  assign is_push = (op == OP_PUSH_BACK) || (op == OP_PUSH_FRONT);
  assign push_ok = is_push && !full;
  assign pop_ok  = !is_push && !empty;
  assign sts.pop_ok = pop_ok;

  assign front_up = (front_r == LAST) ? '0 : front_r + 1'b1;
  assign front_dn = (front_r == '0) ? LAST : front_r - 1'b1;
  assign back_up  = (back_r == LAST) ? '0 : back_r + 1'b1;
  assign back_dn  = (back_r == '0) ? LAST : back_r - 1'b1;

  assign wr_addr = (op == OP_PUSH_FRONT) ? front_dn : back_r;
  assign rd_addr = (op == OP_POP_BACK) ? back_dn : front_r;

  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    if (is_push && full) begin
      status_nxt = ST_FULL;
    end else if (!is_push && empty) begin
      status_nxt = ST_EMPTY;
    end
    case (op)
      OP_PUSH_BACK:  if (push_ok) begin back_nxt = back_up;   end
      OP_PUSH_FRONT: if (push_ok) begin front_nxt = front_dn; end
      OP_POP_FRONT:  if (pop_ok)  begin front_nxt = front_up; end
      OP_POP_BACK:   if (pop_ok)  begin back_nxt = back_dn;   end
      default: ;
    endcase
    if (push_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.exec && push_ok) begin
      mem[wr_addr] <= value;
    end
    if (cmd.exec) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      data_r   <= NO_DATA;
      status_r <= status_nxt;
      occ_r    <= OCC_W'(count_nxt);
    end else if (cmd.finish) begin
      data_r <= rdata_r;
    end
  end

  assign data      = data_r;
  assign status    = status_r;
  assign occupancy = occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("count beyond capacity");

  a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && !push_ok && !pop_ok) |=>
      ($stable(count_r) && $stable(front_r) && $stable(back_r)))
    else $error("refused operation changed queue state");

  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && push_ok) |=> (count_r == $past(count_r) + 1'b1))
    else $error("accepted push did not raise count");

endmodule

@@ rtl/core/double_ended_queue_core.sv @@
// double_ended_queue_core: top level of the 32-bit deque (circular store, push/pop both ends).
// Depends on deq_pkg, deq_ifs, deq_ctrl, deq_dp.
`timescale 1ns / 1ps
//
//  channel   dir  handshake            payload
//  in_ch     in   valid/ready          mode[1:0], value[31:0] signed
//  out_ch    out  valid/ready          data[31:0] signed, status[1:0], occupancy[7:0]
//
//  Push, refused push and refused pop: the result register loads at once, result valid the next cycle.
//  Successful pop: registered store read, then the result register; no new item is taken meanwhile.
//  The result register parts the sides: a new item is taken in the cycle the old
//  result leaves. Reset (rst_n low, synchronous) empties the queue at once; store
//  contents are not cleared and need no clearing pass. Output stalls hold the item.

module double_ended_queue_core import deq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  deq_in_if.sink    in_ch,
  deq_out_if.source out_ch
);

  deq_cmd_t cmd;  // controller -> datapath: accept / load read data
  deq_sts_t sts;  // datapath -> controller: pop will read the store

  // controller owns the handshake and the pop read sequence
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath holds pointers, count, store and the result register
  deq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (in_ch.mode),
    .value     (in_ch.value),
    .cmd       (cmd),
    .sts       (sts),
    .data      (out_ch.data),
    .status    (out_ch.status),
    .occupancy (out_ch.occupancy)
  );

endmodule
